// ===== rtl/core/segtree_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the segment tree range-sum block.
// No dependencies; the walker, the top level and the testbench import this package.
package segtree_pkg;

    localparam int LEAF_COUNT = 1024;
    localparam int LEAF_W     = $clog2(LEAF_COUNT);
    localparam int LEN_W      = LEAF_W + 1;
    // The midpoint split can place nodes well past 2*LEAF_COUNT for lengths
    // that are not powers of two, so the store holds 4*LEAF_COUNT nodes.
    localparam int NODE_SLOTS = 4 * LEAF_COUNT;
    localparam int NODE_AW    = $clog2(NODE_SLOTS);
    localparam int DATA_W     = 32;
    localparam int MAX_DEPTH  = LEAF_W;
    localparam int IN_TDATA_W = 64;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_DOWN,
        ST_UPD_UP,
        ST_QRY_WALK,
        ST_QRY_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        op_t                      op;
        logic [LEAF_W-1:0]        element_index;
        logic signed [DATA_W-1:0] new_value;
        logic [LEAF_W-1:0]        range_first;
        logic [LEAF_W-1:0]        range_last;
    } item_t;

    typedef struct packed {
        logic               wr_en;
        logic [NODE_AW-1:0] wr_addr;
        logic [DATA_W-1:0]  wr_data;
        logic               rd_en;
        logic [NODE_AW-1:0] rd_addr;
    } node_req_t;

endpackage

// ===== rtl/core/segtree_node_ram.sv =====
`timescale 1ns / 1ps
// Generic one-write, one-read synchronous RAM with a registered read port.
// Standalone; used as the node store of the segment tree.
module segtree_node_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/segtree_walker.sv =====
`timescale 1ns / 1ps
// Sequencer that walks the node store: clearing pass, update descent and
// ascent with a sibling stack, and the two-path range query. Uses segtree_pkg.
module segtree_walker import segtree_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [LEN_W-1:0]  array_length,
    input  logic              in_valid,
    output logic              in_ready,
    input  item_t             in_item,
    output node_req_t         mem_req,
    input  logic [DATA_W-1:0] mem_rdata,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [DATA_W-1:0] res_sum
);

    state_t state_reg, state_next;

    logic [NODE_AW-1:0] clr_addr_reg, clr_addr_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               pend_vld_reg, pend_vld_next;

    logic [LEAF_W-1:0]  at_reg, at_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [LEAF_W-1:0]  qa_reg, qa_next;
    logic [LEAF_W-1:0]  qb_reg, qb_next;
    logic [NODE_AW-1:0] p_reg, p_next;
    logic [LEAF_W-1:0]  lo_reg, lo_next;
    logic [LEAF_W-1:0]  hi_reg, hi_next;
    logic [NODE_AW-1:0] pend_p_reg, pend_p_next;
    logic [LEAF_W-1:0]  pend_lo_reg, pend_lo_next;
    logic [LEAF_W-1:0]  pend_hi_reg, pend_hi_next;
    logic [DATA_W-1:0]  acc_reg, acc_next;
    logic [DATA_W-1:0]  sib_reg [MAX_DEPTH];
    logic [DATA_W-1:0]  sib_next [MAX_DEPTH];

    logic [LEN_W-1:0]   n_eff;
    logic [LEN_W-1:0]   last_full;
    logic [LEAF_W-1:0]  last_idx;
    logic               upd_ok;
    logic               qry_ok;
    logic [LEAF_W:0]    mid_sum;
    logic [LEAF_W-1:0]  mid;
    logic [LEAF_W-1:0]  mid_p1;
    logic [NODE_AW-1:0] left_p;
    logic [NODE_AW-1:0] right_p;
    logic [NODE_AW-1:0] p_m1;
    logic [NODE_AW-1:0] parent_p;
    logic               is_leaf;
    logic               covered;
    logic               l_ov;
    logic               r_ov;
    logic               l_cov;
    logic               r_cov;
    logic [DATA_W-1:0]  asc_sum;
    logic [DATA_W-1:0]  acc_add;
    logic               clr_last;

    // Lengths above the leaf count behave as the leaf count.
    assign n_eff     = (array_length > LEN_W'(LEAF_COUNT)) ? LEN_W'(LEAF_COUNT) : array_length;
    assign last_full = n_eff - LEN_W'(1);
    assign last_idx  = last_full[LEAF_W-1:0];
    assign upd_ok    = (n_eff != '0) && ({1'b0, in_item.element_index} < n_eff);
    assign qry_ok    = (n_eff != '0) && (in_item.range_first <= in_item.range_last)
                       && ({1'b0, in_item.range_first} < n_eff);

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[LEAF_W:1];
    assign mid_p1   = mid + LEAF_W'(1);
    assign left_p   = {p_reg[NODE_AW-2:0], 1'b1};
    assign right_p  = left_p + NODE_AW'(1);
    assign p_m1     = p_reg - NODE_AW'(1);
    assign parent_p = {1'b0, p_m1[NODE_AW-1:1]};
    assign is_leaf  = (lo_reg == hi_reg);

    assign covered = (qa_reg <= lo_reg) && (qb_reg >= hi_reg);
    assign l_ov    = (qa_reg <= mid);
    assign r_ov    = (qb_reg > mid);
    assign l_cov   = (qa_reg <= lo_reg) && (qb_reg >= mid);
    assign r_cov   = (qa_reg <= mid_p1) && (qb_reg >= hi_reg);

    assign asc_sum  = val_reg + sib_reg[0];
    assign acc_add  = acc_reg + mem_rdata;
    assign clr_last = (clr_addr_reg == NODE_AW'(NODE_SLOTS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.op == OP_QUERY)
                    begin
                        state_next = qry_ok ? ST_QRY_WALK : ST_RESULT;
                    end
                    else if (upd_ok)
                    begin
                        state_next = ST_UPD_DOWN;
                    end
                end
            end
            ST_UPD_DOWN:
            begin
                if (is_leaf)
                begin
                    state_next = (p_reg == '0) ? ST_IDLE : ST_UPD_UP;
                end
            end
            ST_UPD_UP:
            begin
                if (parent_p == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QRY_WALK:
            begin
                if (covered && !pend_vld_reg)
                begin
                    state_next = ST_QRY_DRAIN;
                end
            end
            ST_QRY_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        rd_vld_next   = 1'b0;
        pend_vld_next = pend_vld_reg;
        at_next       = at_reg;
        val_next      = val_reg;
        qa_next       = qa_reg;
        qb_next       = qb_reg;
        p_next        = p_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        pend_p_next   = pend_p_reg;
        pend_lo_next  = pend_lo_reg;
        pend_hi_next  = pend_hi_reg;
        acc_next      = acc_reg;
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            sib_next[i] = sib_reg[i];
        end
        mem_req   = '0;
        in_ready  = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_RESULT);
        res_sum   = acc_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_addr_reg;
                mem_req.wr_data = '0;
                clr_addr_next   = clr_addr_reg + NODE_AW'(1);
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    at_next       = in_item.element_index;
                    val_next      = in_item.new_value;
                    qa_next       = in_item.range_first;
                    qb_next       = (in_item.range_last > last_idx) ? last_idx
                                                                    : in_item.range_last;
                    p_next        = '0;
                    lo_next       = '0;
                    hi_next       = last_idx;
                    pend_vld_next = 1'b0;
                    acc_next      = '0;
                end
            end
            ST_UPD_DOWN:
            begin
                // Siblings read on the way down are stacked, deepest on top.
                if (rd_vld_reg)
                begin
                    sib_next[0] = mem_rdata;
                    for (int i = 1; i < MAX_DEPTH; i++)
                    begin
                        sib_next[i] = sib_reg[i-1];
                    end
                end
                if (is_leaf)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = p_reg;
                    mem_req.wr_data = val_reg;
                end
                else
                begin
                    mem_req.rd_en = 1'b1;
                    rd_vld_next   = 1'b1;
                    if (at_reg <= mid)
                    begin
                        mem_req.rd_addr = right_p;
                        p_next          = left_p;
                        hi_next         = mid;
                    end
                    else
                    begin
                        mem_req.rd_addr = left_p;
                        p_next          = right_p;
                        lo_next         = mid_p1;
                    end
                end
            end
            ST_UPD_UP:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = parent_p;
                mem_req.wr_data = asc_sum;
                val_next        = asc_sum;
                p_next          = parent_p;
                for (int i = 0; i < MAX_DEPTH - 1; i++)
                begin
                    sib_next[i] = sib_reg[i+1];
                end
            end
            ST_QRY_WALK:
            begin
                if (rd_vld_reg)
                begin
                    acc_next = acc_add;
                end
                if (covered)
                begin
                    // Path ends here; continue with the saved right branch if any.
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = p_reg;
                    rd_vld_next     = 1'b1;
                    if (pend_vld_reg)
                    begin
                        p_next        = pend_p_reg;
                        lo_next       = pend_lo_reg;
                        hi_next       = pend_hi_reg;
                        pend_vld_next = 1'b0;
                    end
                end
                else if (l_ov && r_ov)
                begin
                    if (r_cov)
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = right_p;
                        rd_vld_next     = 1'b1;
                        p_next          = left_p;
                        hi_next         = mid;
                    end
                    else if (l_cov)
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = left_p;
                        rd_vld_next     = 1'b1;
                        p_next          = right_p;
                        lo_next         = mid_p1;
                    end
                    else
                    begin
                        // Split node: both children are partial, so the right one waits.
                        pend_vld_next = 1'b1;
                        pend_p_next   = right_p;
                        pend_lo_next  = mid_p1;
                        pend_hi_next  = hi_reg;
                        p_next        = left_p;
                        hi_next       = mid;
                    end
                end
                else if (l_ov)
                begin
                    p_next  = left_p;
                    hi_next = mid;
                end
                else
                begin
                    p_next  = right_p;
                    lo_next = mid_p1;
                end
            end
            ST_QRY_DRAIN:
            begin
                if (rd_vld_reg)
                begin
                    acc_next = acc_add;
                end
            end
            ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            rd_vld_reg   <= rd_vld_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        at_reg      <= at_next;
        val_reg     <= val_next;
        qa_reg      <= qa_next;
        qb_reg      <= qb_next;
        p_reg       <= p_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        pend_p_reg  <= pend_p_next;
        pend_lo_reg <= pend_lo_next;
        pend_hi_reg <= pend_hi_next;
        acc_reg     <= acc_next;
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            sib_reg[i] <= sib_next[i];
        end
    end

    // The node store never sees a read and a write in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.wr_en && mem_req.rd_en))
        else $error("node store read and write collide");

    // The ascent never starts from the root.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD_UP) |-> (p_reg != '0))
        else $error("ascent entered at the root");

    // A read result is only ever expected while walking or draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == ST_UPD_DOWN || state_reg == ST_QRY_WALK
                        || state_reg == ST_QRY_DRAIN))
        else $error("node read returned outside a walk");

    // Every node visited on a walk spans a non-empty interval.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD_DOWN || state_reg == ST_QRY_WALK) |-> (lo_reg <= hi_reg))
        else $error("walk reached an empty node span");

    // A split is saved at most once per query.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QRY_WALK && pend_vld_reg) |=> !$rose(pend_vld_reg))
        else $error("second pending branch in one query");

endmodule

// ===== rtl/core/segment_tree_range_sum.sv =====
`timescale 1ns / 1ps
// Top level of the segment tree range-sum block: stream ports, length
// register, output register, node store and walker. Uses segtree_pkg.
//
//  Channel  | Direction | Carries
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | one update or query item (tuser selects which)
//  m_axis   | out       | one range sum per query item
//  cfg      | in        | array_length, written while the block is idle
//
// An item is taken only while the walker is idle, so the next one waits until an update
// (descent, then ascent) or a query (walk, then drain) is through; D = ceil(log2(length))
// <= 10 is the tree depth, a query walks V <= 2*D+1 nodes and an empty or inverted query
// goes straight to its zero sum. After reset a clearing pass zeroes all 4096 nodes, with
// s_axis_tready low. A finished sum waits in the output register and the next item
// is taken meanwhile; a second finished sum holds the input off until it drains.
module segment_tree_range_sum import segtree_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [LEN_W-1:0]      cfg_wr_data,   // array_length
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [9:0] element_index, [41:10] new_value, [51:42] range_first,
    // [61:52] range_last, [63:62] zero
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                  s_axis_tuser,  // [0] operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_W-1:0]     m_axis_tdata   // [31:0] range_sum
);

    logic [LEN_W-1:0]  array_length_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg, m_tdata_next;

    item_t             in_item;
    node_req_t         mem_req;
    logic [DATA_W-1:0] mem_rdata;
    logic              res_valid;
    logic              res_ready;
    logic [DATA_W-1:0] res_sum;

    assign in_item.op            = op_t'(s_axis_tuser);
    assign in_item.element_index = s_axis_tdata[LEAF_W-1:0];
    assign in_item.new_value     = s_axis_tdata[LEAF_W+DATA_W-1:LEAF_W];
    assign in_item.range_first   = s_axis_tdata[2*LEAF_W+DATA_W-1:LEAF_W+DATA_W];
    assign in_item.range_last    = s_axis_tdata[3*LEAF_W+DATA_W-1:2*LEAF_W+DATA_W];

    segtree_node_ram #(
        .DEPTH (NODE_SLOTS),
        .WIDTH (DATA_W)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rdata)
    );

    segtree_walker u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .array_length (array_length_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_item      (in_item),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_sum      (res_sum)
    );

    // The walker hands over a sum whenever the output register is free or draining.
    assign res_ready = !m_tvalid_reg || m_axis_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res_sum;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            array_length_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                array_length_reg <= cfg_wr_data;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

// ===== verif/segment_tree_range_sum_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for segment_tree_range_sum: point updates and range
// sum queries over several array lengths, checked against a tree kept here.
// Depends on segtree_pkg and segment_tree_range_sum.
module segment_tree_range_sum_tb;
    import segtree_pkg::*;

    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_ITEMS  = 90;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [LEN_W-1:0]      cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [9:0] element_index, [41:10] new_value, [51:42] range_first,
    // [61:52] range_last, [63:62] zero
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;  // [0] operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;         // [31:0] range_sum

    segment_tree_range_sum i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Tree kept alongside the block, with its own copy of the length.
    logic [DATA_W-1:0] node_sums [NODE_SLOTS];
    logic [LEN_W-1:0]  model_length = '0;
    logic [DATA_W-1:0] pending_sums [$];

    item_t       item_backlog [$];
    item_t       drv_item;
    int unsigned items_queued = 0;
    int unsigned items_accepted = 0;
    int unsigned send_gap = 0;
    int unsigned recv_hold = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          gaps_on = 1'b0;
    bit          long_hold_req = 1'b0;
    bit          long_hold_done = 1'b0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [DATA_W-1:0] node_at(input int unsigned p);
        return (p < NODE_SLOTS) ? node_sums[p] : '0;
    endfunction

    function automatic void write_leaf(input int unsigned p, input int unsigned lo,
                                       input int unsigned hi, input int unsigned at,
                                       input logic [DATA_W-1:0] v);
        int unsigned mid;
        if (p >= NODE_SLOTS || at < lo || at > hi)
            return;
        if (lo == hi)
        begin
            node_sums[p] = v;
            return;
        end
        mid = (lo + hi) / 2;
        write_leaf(2 * p + 1, lo, mid, at, v);
        write_leaf(2 * p + 2, mid + 1, hi, at, v);
        node_sums[p] = node_at(2 * p + 1) + node_at(2 * p + 2);
    endfunction

    function automatic logic [DATA_W-1:0] span_total(input int unsigned p,
                                                     input int unsigned lo,
                                                     input int unsigned hi,
                                                     input int unsigned qa,
                                                     input int unsigned qb);
        int unsigned mid;
        if (qa <= lo && qb >= hi)
            return node_at(p);
        if (qa > hi || qb < lo || p >= NODE_SLOTS)
            return '0;
        mid = (lo + hi) / 2;
        return span_total(2 * p + 1, lo, mid, qa, qb) +
               span_total(2 * p + 2, mid + 1, hi, qa, qb);
    endfunction

    // Applies one accepted item to the tree; a query leaves its sum in pending_sums.
    function automatic void apply_to_tree(input item_t it);
        int unsigned       n;
        int unsigned       qa;
        int unsigned       qb;
        logic [DATA_W-1:0] total;
        n = (32'(model_length) > LEAF_COUNT) ? LEAF_COUNT : 32'(model_length);
        if (it.op == OP_UPDATE)
        begin
            if (n != 0 && 32'(it.element_index) < n)
                write_leaf(0, 0, n - 1, 32'(it.element_index), it.new_value);
        end
        else
        begin
            qa = 32'(it.range_first);
            qb = 32'(it.range_last);
            total = '0;
            if (n != 0 && qa <= qb && qa < n)
            begin
                if (qb > n - 1)
                    qb = n - 1;
                total = span_total(0, 0, n - 1, qa, qb);
            end
            pending_sums.push_back(total);
        end
    endfunction

    // Mostly back to back, sometimes a short pause, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sender: an item stays on the bus until it is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_to_tree(drv_item);
                items_accepted++;
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (item_backlog.size() != 0)
                begin
                    drv_item = item_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= drv_item.op;
                    s_axis_tdata <= {2'b00, drv_item.range_last, drv_item.range_first,
                                     drv_item.new_value, drv_item.element_index};
                    send_gap <= pick_gap();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (recv_hold != 0)
        begin
            recv_hold <= recv_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            long_hold_done <= 1'b1;
            recv_hold <= LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            int unsigned stall;
            stall = pick_gap();
            if (stall == 0)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                recv_hold <= stall - 1;
                m_axis_tready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_sums.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("range sum %h arrived with no query waiting", m_axis_tdata);
            end
            else
            begin
                logic [DATA_W-1:0] wanted;
                wanted = pending_sums.pop_front();
                if (m_axis_tdata !== wanted)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("range_sum mismatch: expected %h, got %h",
                                 wanted, m_axis_tdata);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_update(input int unsigned idx, input logic [DATA_W-1:0] value);
        item_t it;
        it.op = OP_UPDATE;
        it.element_index = LEAF_W'(idx);
        it.new_value = value;
        it.range_first = LEAF_W'($urandom_range(0, 1023));
        it.range_last = LEAF_W'($urandom_range(0, 1023));
        item_backlog.push_back(it);
        items_queued++;
    endtask

    task automatic queue_query(input int unsigned first, input int unsigned last);
        item_t it;
        it.op = OP_QUERY;
        it.element_index = LEAF_W'($urandom_range(0, 1023));
        it.new_value = $urandom;
        it.range_first = LEAF_W'(first);
        it.range_last = LEAF_W'(last);
        item_backlog.push_back(it);
        items_queued++;
    endtask

    // Updates carry no result, so a short settle follows the last sum.
    task automatic wait_idle();
        while (items_accepted != items_queued || pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_length = len;
    endtask

    task automatic random_phase(input logic [LEN_W-1:0] len, input bit with_gaps,
                                input bit with_long_hold);
        int unsigned n;
        int unsigned a;
        int unsigned b;
        logic [DATA_W-1:0] value;
        wait_idle();
        gaps_on = with_gaps;
        write_length(len);
        n = (32'(len) > LEAF_COUNT) ? LEAF_COUNT : 32'(len);
        // Short arrays get every element rewritten first, as software would.
        if (n <= 64)
            for (int unsigned i = 0; i < n; i++)
                queue_update(i, $urandom);
        if (with_long_hold)
            long_hold_req = 1'b1;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if ($urandom_range(0, 99) < 45)
            begin
                if (n != 0 && $urandom_range(0, 9) < 8)
                    a = $urandom_range(0, n - 1);
                else
                    a = $urandom_range(0, 1023);
                case ($urandom_range(0, 9))
                    0:       value = 32'h7FFF_FFFF;
                    1:       value = 32'h8000_0000;
                    default: value = $urandom;
                endcase
                queue_update(a, value);
            end
            else if (n != 0 && $urandom_range(0, 9) < 8)
            begin
                a = $urandom_range(0, n - 1);
                b = ($urandom_range(0, 3) == 0) ? $urandom_range(a, 1023)
                                                : $urandom_range(a, n - 1);
                queue_query(a, b);
            end
            else
            begin
                queue_query($urandom_range(0, 1023), $urandom_range(0, 1023));
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < NODE_SLOTS; i++)
            node_sums[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // The node store is cleared after reset with the input held off.
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);

        // Length still zero from reset: nothing is stored and every sum is zero.
        queue_update(0, 32'h0000_0005);
        queue_query(0, 1023);
        wait_idle();

        gaps_on = 1'b1;
        write_length(11'd1024);
        queue_update(0, 32'h7FFF_FFFF);
        queue_update(1023, 32'h8000_0000);
        queue_update(512, 32'hFFFF_FFFF);
        queue_update(1, 32'h0000_0001);
        queue_query(0, 1023);
        queue_query(0, 0);
        queue_query(1023, 1023);
        queue_query(600, 100);
        queue_query(1, 1022);
        queue_query(0, 1);
        wait_idle();

        // Shrinking the length leaves stale nodes that are read under the new shape.
        write_length(11'd5);
        queue_query(0, 4);
        queue_query(3, 1023);
        queue_query(5, 9);
        queue_update(7, 32'h1234_5678);
        queue_update(4, 32'h0000_0064);
        queue_query(0, 1023);
        queue_query(4, 4);

        random_phase(11'd2047, 1'b1, 1'b0);
        random_phase(11'd1,    1'b1, 1'b0);
        random_phase(11'd2,    1'b0, 1'b0);
        random_phase(11'd37,   1'b1, 1'b0);
        random_phase(11'd1000, 1'b1, 1'b1);
        random_phase(11'd0,    1'b1, 1'b0);
        random_phase(11'd3,    1'b0, 1'b0);
        random_phase(11'd513,  1'b1, 1'b0);
        random_phase(11'd64,   1'b1, 1'b0);
        random_phase(11'd1024, 1'b0, 1'b0);
        random_phase(11'd7,    1'b1, 1'b0);
        random_phase(11'd100,  1'b1, 1'b0);

        wait_idle();
        if (error_count == 0 && pending_sums.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
